@@ design/lcdseq_pkg.sv @@
// ============================================================================
// lcdseq_pkg
// Types, codes and constant tables shared by the character-LCD sequencer.
// ============================================================================
package lcdseq_pkg;

  // Display operations carried in in_tuser
  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_PUTC  = 2'd2,
    OP_GOTO  = 2'd3
  } op_t;

  // Register select levels
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Register indexes on the configuration port
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  localparam logic [5:0] COLUMNS_RESET = 6'd16;
  localparam logic [2:0] ROWS_RESET    = 3'd2;
  localparam logic [2:0] ROWS_MAX      = 3'd4;

  localparam logic [7:0]  CMD_CLEAR  = 8'h01;
  localparam logic        DDRAM_BIT  = 1'b1;   // 0x80, set DDRAM address
  localparam logic [10:0] WAIT_SHORT = 11'd50;
  localparam logic [10:0] WAIT_CLEAR = 11'd2000;

  localparam logic [3:0] INIT_LAST = 4'd11;
  localparam logic [3:0] BYTE_LAST = 4'd1;
  localparam logic [3:0] PAIR_LAST = 4'd3;

  // Queue geometry between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  // One queued job: a full init sequence, or one or two bytes
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] byte0;
    logic       long_wait;   // first byte settles for the clear time
    logic       has_second;  // second byte: address command, short wait
    logic [7:0] byte1;
  } job_t;

  // One enable strobe
  typedef struct packed {
    logic        rs;
    logic [3:0]  nibble;
    logic [15:0] wait_before;
    logic [10:0] wait_after;
  } strobe_t;

  // DDRAM start address of each display line
  function automatic logic [6:0] line_base(input logic [1:0] row);
    logic [6:0] b;
    case (row)
      2'd0:    b = 7'h00;
      2'd1:    b = 7'h40;
      2'd2:    b = 7'h14;
      2'd3:    b = 7'h54;
      default: b = 7'h00;
    endcase
    return b;
  endfunction

  // Power-up sequence, one strobe per step
  function automatic strobe_t init_strobe(input logic [3:0] idx);
    strobe_t s;
    s.rs          = RS_CMD;
    s.nibble      = 4'h0;
    s.wait_before = 16'd0;
    s.wait_after  = 11'd0;
    case (idx)
      4'd0: begin
        s.nibble      = 4'h3;
        s.wait_before = 16'd40000;
      end
      4'd1: begin
        s.nibble      = 4'h3;
        s.wait_before = 16'd5000;
      end
      4'd2: begin
        s.nibble      = 4'h3;
        s.wait_before = 16'd100;
      end
      4'd3:  s.nibble = 4'h2;
      4'd4:  s.nibble = 4'h2;
      4'd5: begin
        s.nibble     = 4'h8;
        s.wait_after = WAIT_SHORT;
      end
      4'd6:  s.nibble = 4'h0;
      4'd7: begin
        s.nibble     = 4'h8;
        s.wait_after = WAIT_SHORT;
      end
      4'd8:  s.nibble = 4'h0;
      4'd9: begin
        s.nibble     = 4'h1;
        s.wait_after = WAIT_CLEAR;
      end
      4'd10: s.nibble = 4'h0;
      4'd11: begin
        s.nibble     = 4'hC;
        s.wait_after = WAIT_SHORT;
      end
      default: s.nibble = 4'h0;
    endcase
    return s;
  endfunction

endpackage

@@ design/lcdseq_front.sv @@
// ============================================================================
// lcdseq_front
// Accepts display operations, tracks the cursor and queues strobe jobs.
// ============================================================================
module lcdseq_front #(
  parameter int MAX_COLUMNS = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [5:0]         cfg_data,
  input  logic               in_tvalid,
  input  logic [1:0]         in_tuser,
  input  logic [23:0]        in_tdata,
  output logic               push,
  output lcdseq_pkg::job_t   job,
  input  logic               q_ready
);
  import lcdseq_pkg::*;

  logic [5:0] columns_r;
  logic [2:0] rows_r;
  logic [5:0] cur_col_r, cur_col_nxt;
  logic [1:0] cur_row_r, cur_row_nxt;

  logic [5:0] eff_cols;
  logic [2:0] eff_rows;
  logic [6:0] nx;
  logic       p_wrap;
  logic [2:0] ny;
  logic [1:0] ny_w;
  logic [7:0] gx, gy, gx2, gy1, gy2;
  logic       g_colwrap, g_rowwrap;
  logic [6:0] g_sum;
  logic [7:0] ch;

  assign ch   = in_tdata[7:0];
  assign gx   = in_tdata[15:8];
  assign gy   = in_tdata[23:16];
  assign push = in_tvalid && q_ready;

  always_comb begin
    eff_cols = columns_r;
    if (columns_r == 6'd0) eff_cols = 6'd1;
    else if (columns_r > 6'(MAX_COLUMNS)) eff_cols = 6'(MAX_COLUMNS);
    eff_rows = rows_r;
    if (rows_r == 3'd0) eff_rows = 3'd1;
    else if (rows_r > ROWS_MAX) eff_rows = ROWS_MAX;
  end

  // Put character: advance column, wrap to next row
  always_comb begin
    nx     = {1'b0, cur_col_r} + 7'd1;
    p_wrap = nx >= {1'b0, eff_cols};
    ny     = {1'b0, cur_row_r} + 3'd1;
    ny_w   = (ny >= eff_rows) ? 2'd0 : ny[1:0];
  end

  // Goto: normalize column, then row
  always_comb begin
    g_colwrap = gx >= {2'b00, eff_cols};
    gx2       = g_colwrap ? 8'd0 : gx;
    gy1       = g_colwrap ? gy + 8'd1 : gy;
    g_rowwrap = gy1 >= {5'b00000, eff_rows};
    gy2       = g_rowwrap ? 8'd0 : gy1;
    g_sum     = line_base(gy2[1:0]) + gx2[6:0];
  end

  always_comb begin
    job         = '0;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    case (op_t'(in_tuser))
      OP_INIT: begin
        job.is_init = 1'b1;
        cur_col_nxt = 6'd0;
        cur_row_nxt = 2'd0;
      end
      OP_CLEAR: begin
        job.rs        = RS_CMD;
        job.byte0     = CMD_CLEAR;
        job.long_wait = 1'b1;
      end
      OP_PUTC: begin
        job.rs    = RS_DATA;
        job.byte0 = ch;
        if (p_wrap) begin
          job.has_second = 1'b1;
          job.byte1      = {DDRAM_BIT, line_base(ny_w)};
          cur_col_nxt    = 6'd0;
          cur_row_nxt    = ny_w;
        end else begin
          cur_col_nxt = nx[5:0];
        end
      end
      OP_GOTO: begin
        job.rs      = RS_CMD;
        job.byte0   = {DDRAM_BIT, g_sum};
        cur_col_nxt = gx2[5:0];
        cur_row_nxt = gy2[1:0];
      end
      default: job = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= COLUMNS_RESET;
      rows_r    <= ROWS_RESET;
      cur_col_r <= 6'd0;
      cur_row_r <= 2'd0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_COLUMNS) columns_r <= cfg_data;
        else                          rows_r    <= cfg_data[2:0];
      end
      if (push) begin
        cur_col_r <= cur_col_nxt;
        cur_row_r <= cur_row_nxt;
      end
    end
  end

endmodule

@@ design/lcdseq_fifo.sv @@
// ============================================================================
// lcdseq_fifo
// Short job queue between the front and the strobe back end.
// ============================================================================
module lcdseq_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  lcdseq_pkg::job_t wr_job,
  output logic             rd_valid,
  input  logic             rd_pop,
  output lcdseq_pkg::job_t rd_job
);
  import lcdseq_pkg::*;

  job_t                mem [Q_DEPTH];
  logic [Q_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]       count_r;
  logic                do_wr, do_rd;

  assign wr_ready = count_r != (Q_AW+1)'(Q_DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_job   = mem[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ design/lcdseq_back.sv @@
// ============================================================================
// lcdseq_back
// Expands queued jobs into enable strobes, one per cycle while the output is free, into an output register.
// ============================================================================
module lcdseq_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  lcdseq_pkg::job_t job,
  output logic             job_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);
  import lcdseq_pkg::*;

  logic [3:0] step_r, step_nxt;
  logic       out_vld_r;
  strobe_t    out_s_r, s;
  logic       out_last_r, last;
  logic       load;
  logic [7:0] cur_byte;
  logic       low_half;

  assign load = job_valid && (!out_vld_r || out_tready);

  always_comb begin
    low_half = step_r[0];
    cur_byte = step_r[1] ? job.byte1 : job.byte0;
    if (job.is_init) begin
      s    = init_strobe(step_r);
      last = step_r == INIT_LAST;
    end else begin
      s.rs          = step_r[1] ? RS_CMD : job.rs;
      s.nibble      = low_half ? cur_byte[3:0] : cur_byte[7:4];
      s.wait_before = 16'd0;
      s.wait_after  = 11'd0;
      if (low_half)
        s.wait_after = (job.long_wait && !step_r[1]) ? WAIT_CLEAR : WAIT_SHORT;
      last = job.has_second ? (step_r == PAIR_LAST) : (step_r == BYTE_LAST);
    end
    step_nxt = last ? 4'd0 : step_r + 4'd1;
  end

  assign job_pop = load && last;

  always_ff @(posedge clk) begin
    if (load) begin
      out_s_r    <= s;
      out_last_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= 4'd0;
      out_vld_r <= 1'b0;
    end else begin
      if (load) step_r <= step_nxt;
      if (load)            out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_s_r.rs;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_s_r.wait_after, out_s_r.wait_before, out_s_r.nibble};

endmodule

@@ design/char_lcd_nibble_command_sequencer_core.sv @@
// ============================================================================
// char_lcd_nibble_command_sequencer_core
// Turns display operations into 4-bit character-LCD enable strobes.
// ============================================================================
// Path: the first strobe of an operation goes through the queue register, then
//   the output register, and waits there until out_tready takes it.
// Throughput: one strobe per cycle out of the back end strobe counter while the
//   output is taken; an operation gives 2 strobes (clear, plain character,
//   goto), 4 (character that wraps) or 12 (init). Input is taken once per cycle
//   while the 2-entry job queue has room, also while a strobe waits at the output.
// Reset: rst_n, synchronous, clears cursor, queue and output; columns 16, rows 2.
module char_lcd_nibble_command_sequencer_core #(
  parameter int MAX_COLUMNS = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes: index 0 columns, index 1 rows
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  // operation stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] char_code, [15:8] target_column,
                                  // [23:16] target_row
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // strobe stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [3:0] data_nibble, [19:4] wait_before_us,
                                  // [30:20] wait_after_us, [31] zero
  output logic        out_tuser,  // [0] register_select
  output logic        out_tlast   // last strobe of the operation
);
  import lcdseq_pkg::*;

  logic push, q_ready, q_valid, q_pop;
  job_t front_job, head_job;

  // Configuration writes go straight into the registers; never stall the port
  assign cfg_ready = 1'b1;
  // Take an operation whenever the queue can hold its job
  assign in_tready = q_ready;

  // Front: classify the operation, move the cursor, build the job
  lcdseq_front #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .push      (push),
    .job       (front_job),
    .q_ready   (q_ready)
  );

  // Queue: decouple classification from strobe generation
  lcdseq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push),
    .wr_ready (q_ready),
    .wr_job   (front_job),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_job   (head_job)
  );

  // Back: step through the strobes of the head job, drop it after the last
  lcdseq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (q_valid),
    .job        (head_job),
    .job_pop    (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
